### rtl/core/quad_x_motor_mixer_core_defines.svh
// Assertion macros for the motor mixer core.
`ifndef QUAD_X_MOTOR_MIXER_CORE_DEFINES_SVH
`define QUAD_X_MOTOR_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define QXMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define QXMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/qxmm_pkg.sv
// Shared constants and types of the motor mixer core.
`default_nettype none
package qxmm_pkg;
   localparam int NUM_MOTORS = 4;
   localparam int CMD_W      = 32;
   localparam int THR_W      = 11;
   localparam int RPM_W      = 16;

   // mixing coefficients divided by Kf, Q.8
   localparam logic [22:0] COEF_QUARTER = 23'd6293019;
   localparam logic [28:0] COEF_YAW     = 29'd308028160;
   localparam logic [19:0] RADS_TO_RPM  = 20'd625822;
   localparam logic [10:0] DSHOT_SPAN   = 11'd1999;
   localparam logic [10:0] DSHOT_LOW    = 11'd48;

   localparam logic [RPM_W-1:0] RESET_MIN_RPM = 16'd5000;
   localparam logic [RPM_W-1:0] RESET_MAX_RPM = 16'd15275;

   // square root: 56-bit radicand, 28 root bits, one bit per cell
   localparam int RAD_W  = 56;
   localparam int ROOT_W = 28;
   localparam int REM_W  = 30;
   localparam int NUM_SQ_CELLS = ROOT_W;

   // division: 27-bit numerator, quotient below 2048, one bit per cell
   localparam int NUMER_W = 27;
   localparam int QUO_W   = 11;
   localparam int NUM_DIV_CELLS = QUO_W;

   localparam int MIX_STAGES = 3;
   localparam int RPM_STAGES = 3;
   localparam int PIPE_DEPTH = MIX_STAGES + NUM_SQ_CELLS + RPM_STAGES + NUM_DIV_CELLS;

   // per-motor sign pattern, set bit = negate; bit0 thrust, 1 roll, 2 pitch, 3 yaw
   localparam logic [3:0] MIX_NEG [NUM_MOTORS] = '{4'b1010, 4'b0000, 4'b1100, 4'b0110};

   typedef enum logic [7:0] {
      CSR_MIN_RPM = 8'd0,
      CSR_MAX_RPM = 8'd1
   } csr_index_type;
endpackage
`default_nettype wire

### rtl/core/qxmm_mix_lane.sv
// Mixing, coefficient multiply and magnitude for one motor.
`default_nettype none
module qxmm_mix_lane
   import qxmm_pkg::*;
#(
   parameter logic [3:0] NEG = 4'b0000
) (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire logic [4*CMD_W-1:0]    cmd_i,
   output logic      [RAD_W-1:0]      rad_o
);
   logic signed [33:0] t_s, r_s, p_s, a_in, a_ff;
   logic signed [32:0] b_in, b_ff;
   logic signed [57:0] pq_in, pq_ff;
   logic signed [62:0] py_in, py_ff;
   logic signed [63:0] sum;
   logic        [63:0] mag;
   logic [RAD_W-1:0]   rad_in, rad_ff;

   always_comb begin
      t_s = 34'(signed'(cmd_i[31:0]));
      r_s = 34'(signed'(cmd_i[63:32]));
      p_s = 34'(signed'(cmd_i[95:64]));
      a_in = (NEG[0] ? -t_s : t_s) + (NEG[1] ? -r_s : r_s) + (NEG[2] ? -p_s : p_s);
      b_in = NEG[3] ? -33'(signed'(cmd_i[127:96])) : 33'(signed'(cmd_i[127:96]));
      pq_in = a_ff * $signed({1'b0, COEF_QUARTER});
      py_in = b_ff * $signed({1'b0, COEF_YAW});
      sum = 64'(pq_ff) + 64'(py_ff);
      mag = sum[63] ? 64'(-sum) : 64'(sum);
      rad_in = mag[63:8];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         pq_ff  <= pq_in;
         py_ff  <= py_in;
         rad_ff <= rad_in;
      end
   end

   assign rad_o = rad_ff;
endmodule
`default_nettype wire

### rtl/core/qxmm_sqrt_cell.sv
// One digit step of the integer square root.
`default_nettype none
module qxmm_sqrt_cell
   import qxmm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [RAD_W-1:0]  rad_i,
   input  wire logic [ROOT_W-1:0] root_i,
   input  wire logic [REM_W-1:0]  rem_i,
   output logic      [RAD_W-1:0]  rad_o,
   output logic      [ROOT_W-1:0] root_o,
   output logic      [REM_W-1:0]  rem_o
);
   logic [REM_W-1:0]  rem_t, trial, rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;
   logic [RAD_W-1:0]  rad_ff;

   always_comb begin
      rem_t = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial = {root_i, 2'b01};
      if (rem_t >= trial) begin
         rem_in  = rem_t - trial;
         root_in = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_t;
         root_in = {root_i[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= {rad_i[RAD_W-3:0], 2'b00};
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign rad_o  = rad_ff;
   assign root_o = root_ff;
   assign rem_o  = rem_ff;
endmodule
`default_nettype wire

### rtl/core/qxmm_rpm_lane.sv
// Speed to rpm, clamp and throttle numerator for one motor.
`default_nettype none
module qxmm_rpm_lane
   import qxmm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic [ROOT_W-1:0]  rads_i,
   input  wire logic [RPM_W-1:0]   min_rpm,
   input  wire logic [RPM_W-1:0]   max_rpm,
   output logic      [NUMER_W-1:0] numer_o
);
   logic [47:0]        prod_ff;
   logic [23:0]        rpm_full;
   logic [RPM_W-1:0]   rpm_clamp, diff_ff;
   logic [NUMER_W-1:0] numer_ff;

   always_comb begin
      rpm_full = prod_ff[47:24];
      rpm_clamp = (rpm_full > 24'(max_rpm)) ? max_rpm : rpm_full[RPM_W-1:0];
      if (rpm_clamp < min_rpm) rpm_clamp = min_rpm;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= 48'(rads_i) * 48'(RADS_TO_RPM);
         diff_ff  <= rpm_clamp - min_rpm;
         numer_ff <= NUMER_W'(diff_ff) * NUMER_W'(DSHOT_SPAN);
      end
   end

   assign numer_o = numer_ff;
endmodule
`default_nettype wire

### rtl/core/qxmm_div_cell.sv
// One quotient bit of the throttle division.
`default_nettype none
module qxmm_div_cell
   import qxmm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [RPM_W-1:0]  den_i,
   input  wire logic [QUO_W-1:0]  num_i,
   input  wire logic [RPM_W-1:0]  rem_i,
   input  wire logic [QUO_W-1:0]  quo_i,
   output logic      [QUO_W-1:0]  num_o,
   output logic      [RPM_W-1:0]  rem_o,
   output logic      [QUO_W-1:0]  quo_o
);
   logic [RPM_W:0]   rem_t;
   logic [RPM_W-1:0] rem_in, rem_ff;
   logic [QUO_W-1:0] quo_in, quo_ff, num_ff;

   always_comb begin
      rem_t = {rem_i, num_i[QUO_W-1]};
      if (rem_t >= {1'b0, den_i}) begin
         rem_in = RPM_W'(rem_t - {1'b0, den_i});
         quo_in = {quo_i[QUO_W-2:0], 1'b1};
      end else begin
         rem_in = rem_t[RPM_W-1:0];
         quo_in = {quo_i[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= {num_i[QUO_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign num_o = num_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
endmodule
`default_nettype wire

### rtl/core/quad_x_motor_mixer_core.sv
// Top level of the X-frame quadcopter motor mixer.
// Takes one command (thrust, roll, pitch, yaw, Q16.16) per cycle unless held
// and returns four DShot throttles (48..2047) after 3 mix/multiply stages, 28
// square-root cells (one root bit each), 3 rpm/clamp stages, 11 divider cells
// (one quotient bit each) and the output register. All stages advance together;
// they hold only when the last stage has an item and the output register still
// waits to be taken, so a new item is taken while a result waits. min_rpm
// (index 0) and max_rpm (index 1) are written through the csr port; the user
// must write them only while the block is idle; the block does not enforce
// it. When max_rpm <= min_rpm all throttles read 48; other indexes are dropped.
`default_nettype none
`include "quad_x_motor_mixer_core_defines.svh"
module quad_x_motor_mixer_core
   import qxmm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // thrust_cmd[31:0], roll_cmd[63:32], pitch_cmd[95:64], yaw_cmd[127:96]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // front_right[10:0], rear_right[21:11], front_left[32:22],
   // rear_left[43:33], zero pad [47:44]
   output logic      [47:0]  rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   localparam int LAST = PIPE_DEPTH - 1;

   logic                    adv;
   logic [PIPE_DEPTH-1:0]   vld_ff, vld_in;
   logic [RPM_W-1:0]        min_rpm_ff, max_rpm_ff;
   logic                    empty_range;
   logic [RPM_W-1:0]        den;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [4*THR_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [RAD_W-1:0]   sq_rad  [NUM_MOTORS][NUM_SQ_CELLS+1];
   logic [ROOT_W-1:0]  sq_root [NUM_MOTORS][NUM_SQ_CELLS+1];
   logic [REM_W-1:0]   sq_rem  [NUM_MOTORS][NUM_SQ_CELLS+1];
   logic [NUMER_W-1:0] numer   [NUM_MOTORS];
   logic [QUO_W-1:0]   dv_num  [NUM_MOTORS][NUM_DIV_CELLS+1];
   logic [RPM_W-1:0]   dv_rem  [NUM_MOTORS][NUM_DIV_CELLS+1];
   logic [QUO_W-1:0]   dv_quo  [NUM_MOTORS][NUM_DIV_CELLS+1];

   // pipe stalls only when the finished item cannot enter the output register
   assign adv        = !(vld_ff[LAST] && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   assign empty_range = (max_rpm_ff <= min_rpm_ff);
   assign den         = max_rpm_ff - min_rpm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rpm_ff <= RESET_MIN_RPM;
         max_rpm_ff <= RESET_MAX_RPM;
      end else if (csr_valid) begin
         if (csr_index == CSR_MIN_RPM) min_rpm_ff <= csr_wdata;
         if (csr_index == CSR_MAX_RPM) max_rpm_ff <= csr_wdata;
      end
   end

   for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
      qxmm_mix_lane #(.NEG(MIX_NEG[m])) u_mix (
         .clock (clock),
         .adv   (adv),
         .cmd_i (req_tdata),
         .rad_o (sq_rad[m][0])
      );
      assign sq_root[m][0] = '0;
      assign sq_rem[m][0]  = '0;

      for (genvar c = 0; c < NUM_SQ_CELLS; c++) begin : g_sq
         qxmm_sqrt_cell u_cell (
            .clock  (clock),
            .adv    (adv),
            .rad_i  (sq_rad[m][c]),
            .root_i (sq_root[m][c]),
            .rem_i  (sq_rem[m][c]),
            .rad_o  (sq_rad[m][c+1]),
            .root_o (sq_root[m][c+1]),
            .rem_o  (sq_rem[m][c+1])
         );
      end

      qxmm_rpm_lane u_rpm (
         .clock   (clock),
         .adv     (adv),
         .rads_i  (sq_root[m][NUM_SQ_CELLS]),
         .min_rpm (min_rpm_ff),
         .max_rpm (max_rpm_ff),
         .numer_o (numer[m])
      );

      // quotient fits in 11 bits, so the top bits start as the remainder
      assign dv_rem[m][0] = numer[m][NUMER_W-1 -: RPM_W];
      assign dv_num[m][0] = numer[m][QUO_W-1:0];
      assign dv_quo[m][0] = '0;

      for (genvar c = 0; c < NUM_DIV_CELLS; c++) begin : g_dv
         qxmm_div_cell u_cell (
            .clock (clock),
            .adv   (adv),
            .den_i (den),
            .num_i (dv_num[m][c]),
            .rem_i (dv_rem[m][c]),
            .quo_i (dv_quo[m][c]),
            .num_o (dv_num[m][c+1]),
            .rem_o (dv_rem[m][c+1]),
            .quo_o (dv_quo[m][c+1])
         );
      end

      assign rsp_data_in[m*THR_W +: THR_W] =
         empty_range ? DSHOT_LOW : DSHOT_LOW + dv_quo[m][NUM_DIV_CELLS];
   end

   always_comb begin
      vld_in = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
      if (adv && vld_ff[LAST]) rsp_valid_in = 1'b1;
      else if (rsp_tready)     rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[LAST]) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   `QXMM_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      vld_ff[LAST] && rsp_valid_ff && !rsp_tready, !req_tready,
      "input taken while pipe is blocked")
   `QXMM_ASSERT_NEXT(a_last_loads_output, clock, reset,
      adv && vld_ff[LAST], rsp_valid_ff, "finished item did not reach output")
   `QXMM_ASSERT_NOW(a_throttle_floor, clock, reset,
      rsp_valid_ff, rsp_data_ff[10:0] >= DSHOT_LOW && rsp_data_ff[43:33] >= DSHOT_LOW,
      "throttle below DShot floor")
endmodule
`default_nettype wire

### sim/quad_x_motor_mixer_core_checker.sv
// Output checker for the motor mixer core: predicts throttles and compares.
`timescale 1ns / 100ps
module quad_x_motor_mixer_core_checker
   import qxmm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [47:0]  rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output int                err_count,
   output int                pending
);
   logic [15:0] lo_rpm, hi_rpm;
   logic [43:0] throttle_q[$];

   function automatic logic [63:0] sqrt_floor(logic [63:0] m);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > m) bitv >>= 2;
      while (bitv != 0) begin
         if (m >= res + bitv) begin
            m -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [10:0] motor_dshot(logic [127:0] d, int m);
      logic signed [63:0] sum, c, cf;
      logic [63:0] mag, rpm;
      sum = 0;
      if (hi_rpm <= lo_rpm) return DSHOT_LOW;
      for (int k = 0; k < 4; k++) begin
         c = 64'(signed'(d[32*k +: 32]));
         cf = (k == 3) ? 64'sd308028160 : 64'sd6293019;
         if (MIX_NEG[m][k]) sum -= c * cf;
         else sum += c * cf;
      end
      mag = sum[63] ? -sum : sum;
      rpm = (sqrt_floor(mag >> 8) * 64'd625822) >> 24;
      if (rpm > hi_rpm) rpm = hi_rpm;
      if (rpm < lo_rpm) rpm = lo_rpm;
      return 11'(64'd48 + ((rpm - lo_rpm) * 64'd1999) / (hi_rpm - lo_rpm));
   endfunction

   assign pending = throttle_q.size();

   always @(posedge clock) begin
      logic [43:0] want;
      int          errs;
      if (reset) begin
         lo_rpm <= RESET_MIN_RPM;
         hi_rpm <= RESET_MAX_RPM;
         err_count <= 0;
         throttle_q.delete();
      end else begin
         errs = 0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_RPM) lo_rpm <= csr_wdata;
            else if (csr_index == CSR_MAX_RPM) hi_rpm <= csr_wdata;
         end
         if (req_tvalid && req_tready)
            throttle_q.push_back({motor_dshot(req_tdata, 3), motor_dshot(req_tdata, 2),
                                  motor_dshot(req_tdata, 1), motor_dshot(req_tdata, 0)});
         if (rsp_tvalid && rsp_tready) begin
            if (throttle_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
               errs = errs + 1;
            end else begin
               want = throttle_q.pop_front();
               for (int m = 0; m < 4; m++)
                  if (rsp_tdata[11*m +: 11] !== want[11*m +: 11]) begin
                     $display("%0t: motor %0d expected %0d actual %0d", $time, m,
                              want[11*m +: 11], rsp_tdata[11*m +: 11]);
                     errs = errs + 1;
                  end
               if (rsp_tdata[47:44] !== 4'd0) begin
                  $display("%0t: pad expected 0 actual %h", $time, rsp_tdata[47:44]);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0) err_count <= err_count + errs;
      end
   end
endmodule

### sim/quad_x_motor_mixer_core_tb.sv
// Testbench top for the motor mixer core: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module quad_x_motor_mixer_core_tb;
   import qxmm_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [47:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;
   int           err_count, pending;
   int           quiet_cycles = 0;
   bit           hold_off = 0;   // long receiver stall phase
   bit           stim_done = 0;

   quad_x_motor_mixer_core u_top (.*);

   quad_x_motor_mixer_core_checker u_chk (.*);

   initial forever #6 clock = ~clock;

   // Pick a command word: extremes, small values, or fully random.
   function automatic logic [31:0] pick_cmd();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3, 4: return 32'($signed($urandom_range(0, 8192)) - 4096) <<< 12;
         5, 6: return 32'($urandom_range(0, 40000)) << 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_cmd(logic [127:0] d);
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // gaps: mostly none or short, rarely long
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                           : $urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // Let the pipe drain fully before touching the registers.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Receiver readiness, with one long hold-off while items keep coming.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (120) @(posedge clock);
            hold_off = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Watchdog: cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
         $display("quad_x_motor_mixer_core_tb: errors");
         $finish;
      end
   end

   initial begin
      logic [15:0] lo, hi;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero, extremes, thrust, roll and pitch each alone, negative squared speed.
      send_cmd('0);
      send_cmd({4{32'h7FFF_FFFF}});
      send_cmd({4{32'h8000_0000}});
      send_cmd({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_cmd({32'd0, 32'd0, 32'd0, 32'h0001_0000});
      send_cmd({32'd0, 32'd0, 32'h0001_0000, 32'd0});
      send_cmd({32'd0, 32'h0001_0000, 32'd0, 32'd0});
      send_cmd({32'd0, 32'd0, 32'd0, 32'h0000_8000});   // near hover thrust
      send_cmd({32'd0, 32'd0, 32'd0, 32'hFFFF_0000});   // negative thrust
      send_cmd({32'h0000_0100, 32'hFFFF_8000, 32'h0000_4000, 32'h0000_C000});
      send_cmd({32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'h0002_0000});
      // fill the pipe against a stalled receiver
      hold_off = 1;
      for (int i = 0; i < 80; i++)
         send_cmd({pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd()});
      drain();

      // Register settings: extremes, empty range, inverted range, random.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin lo = 16'd0;     hi = 16'hFFFF; end
            1: begin lo = 16'd0;     hi = 16'd1;    end
            2: begin lo = 16'd9000;  hi = 16'd9000; end
            3: begin lo = 16'hFFFF;  hi = 16'd0;    end
            4: begin lo = 16'hFFFE;  hi = 16'hFFFF; end
            5: begin lo = 16'd1000;  hi = 16'd30000; end
            default: begin lo = 16'($urandom); hi = 16'($urandom); end
         endcase
         write_reg(CSR_MIN_RPM, lo);
         write_reg(CSR_MAX_RPM, hi);
         if (phase == 3) write_reg(csr_index_type'(8'd200), 16'h1234);  // dropped
         for (int i = 0; i < 50; i++)
            send_cmd({pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd()});
         drain();
      end
      write_reg(CSR_MIN_RPM, RESET_MIN_RPM);
      write_reg(CSR_MAX_RPM, RESET_MAX_RPM);
      for (int i = 0; i < 50; i++)
         send_cmd({pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd()});
      req_tvalid <= 0;
      stim_done = 1;
   end

   // Verdict once all expected items have come back.
   initial begin
      wait (stim_done);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (err_count == 0)
         $display("quad_x_motor_mixer_core_tb: clean");
      else
         $display("quad_x_motor_mixer_core_tb: errors");
      $finish;
   end
endmodule
